// File: hw/rtl/cef_pkg.sv
`default_nettype none
package cef_pkg;

	localparam int DEPTH         = 512;
	localparam int PAYLOAD_BYTES = 8;
	localparam int PTR_W         = $clog2(DEPTH);

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	localparam logic [63:0] TEXT_MASK = (PAYLOAD_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (PAYLOAD_BYTES * 8)) - 64'd1);

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [5:0] EV_FRAME  = 6'd0;
	localparam logic [5:0] EV_RESIZE = 6'd1;
	localparam logic [5:0] EV_DRAG   = 6'd2;
	localparam logic [5:0] EV_SCROLL = 6'd3;
	localparam logic [5:0] EV_CLICK  = 6'd4;
	localparam logic [5:0] EV_TEXT   = 6'd5;
	localparam logic [5:0] EV_PASTE  = 6'd6;

	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_MERGED = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_POPPED = 3'd3;
	localparam logic [2:0] ST_EMPTY  = 3'd4;

	typedef struct packed {
		logic              func;
		logic [5:0]        kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [63:0]       payload;
	} req_t;

	typedef struct packed {
		logic             we_kind;
		logic             we_xy;
		logic             we_pl;
		logic [PTR_W-1:0] waddr;
		logic [5:0]       wkind;
		logic [31:0]      wxy;
		logic [63:0]      wpl;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_cmd_t;

	function automatic logic has_xy(input logic [5:0] k);
		return (k >= EV_RESIZE) && (k <= EV_CLICK);
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cef_req_if.sv
`default_nettype none
interface cef_req_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic [5:0]        kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [63:0]       payload;

	modport source(output valid, func, kind, pos_x, pos_y, payload, input ready);
	modport sink(input valid, func, kind, pos_x, pos_y, payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cef_rsp_if.sv
`default_nettype none
interface cef_rsp_if;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [5:0]        out_kind;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [63:0]       out_payload;

	modport source(output valid, status, out_kind, out_x, out_y, out_payload, input ready);
	modport sink(input valid, status, out_kind, out_x, out_y, out_payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cef_mem.sv
`default_nettype none
module cef_mem (
	input  wire logic              clk,
	input  wire cef_pkg::mem_cmd_t cmd,
	output logic [5:0]             rd_kind,
	output logic [31:0]            rd_xy,
	output logic [63:0]            rd_pl
);

	logic [5:0]  kind_mem [cef_pkg::DEPTH];
	logic [31:0] xy_mem   [cef_pkg::DEPTH];
	logic [63:0] pl_mem   [cef_pkg::DEPTH];

	logic [5:0]  rd_kind_q;
	logic [31:0] rd_xy_q;
	logic [63:0] rd_pl_q;

	always_ff @(posedge clk) begin
		if (cmd.we_kind) begin
			kind_mem[cmd.waddr] <= cmd.wkind;
		end
		if (cmd.we_xy) begin
			xy_mem[cmd.waddr] <= cmd.wxy;
		end
		if (cmd.we_pl) begin
			pl_mem[cmd.waddr] <= cmd.wpl;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rd_kind_q <= kind_mem[cmd.raddr];
			rd_xy_q   <= xy_mem[cmd.raddr];
			rd_pl_q   <= pl_mem[cmd.raddr];
		end
	end

	assign rd_kind = rd_kind_q;
	assign rd_xy   = rd_xy_q;
	assign rd_pl   = rd_pl_q;

endmodule
`default_nettype wire

// File: hw/rtl/cef_ctrl.sv
`default_nettype none
module cef_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire cef_pkg::req_t     req,
	output cef_pkg::mem_cmd_t      cmd,
	output logic [2:0]             status
);

	logic [cef_pkg::PTR_W-1:0] wr_ptr_q;
	logic [cef_pkg::PTR_W-1:0] rd_ptr_q;
	logic [5:0]                newest_kind_q;
	logic [31:0]               newest_xy_q;

	logic                      empty;
	logic                      full;
	logic                      merge;
	logic [cef_pkg::PTR_W-1:0] wr_next;
	logic [cef_pkg::PTR_W-1:0] rd_next;
	logic [cef_pkg::PTR_W-1:0] newest_ptr;
	logic [31:0]               in_xy;
	logic [31:0]               merged_xy;
	logic                      upd_newest;
	logic                      adv_wr;
	logic                      adv_rd;

	assign empty      = (wr_ptr_q == rd_ptr_q);
	assign wr_next    = (wr_ptr_q == cef_pkg::LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next    = (rd_ptr_q == cef_pkg::LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
	assign newest_ptr = (wr_ptr_q == '0) ? cef_pkg::LAST_SLOT : wr_ptr_q - 1'b1;
	assign full       = (wr_next == rd_ptr_q);
	assign in_xy      = {req.pos_y, req.pos_x};

	// newest entry lives in registers, so a merge needs no memory read
	assign merge = !empty && (newest_kind_q == req.kind) && (req.kind <= cef_pkg::EV_SCROLL);

	always_comb begin
		merged_xy = in_xy;
		if (req.kind == cef_pkg::EV_SCROLL) begin
			merged_xy = {newest_xy_q[31:16] + req.pos_y, newest_xy_q[15:0] + req.pos_x};
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.raddr  = rd_ptr_q;
		cmd.wkind  = req.kind;
		cmd.wxy    = in_xy;
		cmd.wpl    = (req.kind == cef_pkg::EV_TEXT) ? (req.payload & cef_pkg::TEXT_MASK)
			: req.payload;
		cmd.waddr  = wr_ptr_q;
		status     = cef_pkg::ST_STORED;
		upd_newest = 1'b0;
		adv_wr     = 1'b0;
		adv_rd     = 1'b0;
		if (req.func == cef_pkg::FUNC_PUSH) begin
			if (merge) begin
				status = cef_pkg::ST_MERGED;
				if (req.kind != cef_pkg::EV_FRAME) begin
					cmd.waddr  = newest_ptr;
					cmd.wxy    = merged_xy;
					cmd.we_xy  = accept;
					upd_newest = accept;
				end
			end else if (full) begin
				status = cef_pkg::ST_FULL;
			end else begin
				status      = cef_pkg::ST_STORED;
				cmd.we_kind = accept;
				cmd.we_xy   = accept && cef_pkg::has_xy(req.kind);
				cmd.we_pl   = accept && ((req.kind == cef_pkg::EV_TEXT) ||
					(req.kind == cef_pkg::EV_PASTE));
				upd_newest  = accept;
				adv_wr      = accept;
			end
		end else begin
			if (empty) begin
				status = cef_pkg::ST_EMPTY;
			end else begin
				status = cef_pkg::ST_POPPED;
				cmd.re = accept;
				adv_rd = accept;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (adv_wr) begin
				wr_ptr_q <= wr_next;
			end
			if (adv_rd) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_newest) begin
			newest_kind_q <= req.kind;
			newest_xy_q   <= cmd.wxy;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/coalescing_event_fifo_top.sv
`default_nettype none
// coalescing event fifo
// req channel takes one item per cycle while ready: func selects push or pop.
// rsp channel returns exactly one item per request, in request order, with
// a status (stored, merged, refused full, popped, refused empty) and, for a
// pop, the oldest queued event.
// a frame, resize, drag or scroll push matching the newest entry's kind is
// merged into it (frames dropped, resize/drag overwrite x,y, scroll adds x,y).
// the queue holds DEPTH-1 entries in a single-port-write, one-read memory
// with a registered read; the newest entry is mirrored in registers.
// a response's status is registered on the accepting edge, when the memory
// read is made, and then moves with the read data into the output register,
// from which it is offered on rsp.
// throughput: one item per cycle while rsp.ready stays high.
// when the receiver stalls, one response waits in the output register and
// one in the stage behind it; req.ready then drops until rsp moves again.
// reset clears both pointers, so the queue starts empty; memory contents
// need no clearing.
module coalescing_event_fifo_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cef_req_if.sink     req,
	cef_rsp_if.source   rsp
);

	cef_pkg::req_t     req_item;
	cef_pkg::mem_cmd_t cmd;
	logic [2:0]        status;
	logic [5:0]        rd_kind;
	logic [31:0]       rd_xy;
	logic [63:0]       rd_pl;
	logic              accept;
	logic              s1_move;

	logic              s1_valid_s1;
	logic [2:0]        s1_status_s1;

	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [5:0]        out_kind_q;
	logic [31:0]       out_xy_q;
	logic [63:0]       out_pl_q;

	logic [5:0]        fmt_kind;
	logic [31:0]       fmt_xy;
	logic [63:0]       fmt_pl;

	assign req_item = '{func: req.func, kind: req.kind, pos_x: req.pos_x,
		pos_y: req.pos_y, payload: req.payload};

	assign s1_move   = s1_valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_s1 || s1_move;
	assign accept    = req.valid && req.ready;

	cef_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req_item),
		.cmd    (cmd),
		.status (status)
	);

	cef_mem u_mem (
		.clk     (clk),
		.cmd     (cmd),
		.rd_kind (rd_kind),
		.rd_xy   (rd_xy),
		.rd_pl   (rd_pl)
	);

	// fields without meaning for the kind read as zero
	always_comb begin
		fmt_kind = '0;
		fmt_xy   = '0;
		fmt_pl   = '0;
		if (s1_status_s1 == cef_pkg::ST_POPPED) begin
			fmt_kind = rd_kind;
			if (cef_pkg::has_xy(rd_kind)) begin
				fmt_xy = rd_xy;
			end else if ((rd_kind == cef_pkg::EV_TEXT) || (rd_kind == cef_pkg::EV_PASTE)) begin
				fmt_pl = rd_pl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_status_s1 <= status;
		end
		if (s1_move) begin
			out_status_q <= s1_status_s1;
			out_kind_q   <= fmt_kind;
			out_xy_q     <= fmt_xy;
			out_pl_q     <= fmt_pl;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.out_kind    = out_kind_q;
	assign rsp.out_x       = out_xy_q[15:0];
	assign rsp.out_y       = out_xy_q[31:16];
	assign rsp.out_payload = out_pl_q;

endmodule
`default_nettype wire

// File: tb/cef_tb_pkg.sv
`timescale 1ns / 100ps
package cef_tb_pkg;
	import cef_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [63:0] payload;
	} ev_rsp_t;

	class event_fifo_checker;
		logic [5:0]  kind_mem[DEPTH];
		logic [15:0] x_mem[DEPTH];
		logic [15:0] y_mem[DEPTH];
		logic [63:0] pl_mem[DEPTH];
		int wr = 0;
		int rd = 0;
		ev_rsp_t awaited[$];
		int errors = 0;

		function int occupancy();
			return (wr - rd + DEPTH) % DEPTH;
		endfunction

		function void report(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endfunction

		// works out the response of one accepted item and updates the queue state
		function void take_request(req_t r);
			ev_rsp_t e;
			int newest;
			e = '0;
			newest = (wr + DEPTH - 1) % DEPTH;
			if (r.func == FUNC_POP) begin
				if (wr == rd) begin
					e.status = ST_EMPTY;
				end else begin
					e.status = ST_POPPED;
					e.kind = kind_mem[rd];
					if (kind_mem[rd] >= EV_RESIZE && kind_mem[rd] <= EV_CLICK) begin
						e.x = x_mem[rd];
						e.y = y_mem[rd];
					end else if (kind_mem[rd] == EV_TEXT || kind_mem[rd] == EV_PASTE) begin
						e.payload = pl_mem[rd];
					end
					rd = (rd + 1) % DEPTH;
				end
			end else if (wr != rd && kind_mem[newest] == r.kind && r.kind <= EV_SCROLL) begin
				// merge wins even on a full queue; a frame is just dropped
				e.status = ST_MERGED;
				if (r.kind == EV_SCROLL) begin
					x_mem[newest] = x_mem[newest] + r.pos_x;
					y_mem[newest] = y_mem[newest] + r.pos_y;
				end else if (r.kind != EV_FRAME) begin
					x_mem[newest] = r.pos_x;
					y_mem[newest] = r.pos_y;
				end
			end else if ((wr + 1) % DEPTH == rd) begin
				e.status = ST_FULL;
			end else begin
				e.status = ST_STORED;
				kind_mem[wr] = r.kind;
				if (r.kind >= EV_RESIZE && r.kind <= EV_CLICK) begin
					x_mem[wr] = r.pos_x;
					y_mem[wr] = r.pos_y;
				end else if (r.kind == EV_TEXT) begin
					pl_mem[wr] = r.payload & TEXT_MASK;
				end else if (r.kind == EV_PASTE) begin
					pl_mem[wr] = r.payload;
				end
				wr = (wr + 1) % DEPTH;
			end
			awaited.push_back(e);
		endfunction

		function void check_response(ev_rsp_t got);
			ev_rsp_t want;
			if (awaited.size() == 0) begin
				report($sformatf("response with nothing outstanding, status %0d", got.status));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.kind !== want.kind)
				report($sformatf("out_kind %0d, want %0d", got.kind, want.kind));
			if (got.x !== want.x)
				report($sformatf("out_x %h, want %h", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("out_y %h, want %h", got.y, want.y));
			if (got.payload !== want.payload)
				report($sformatf("out_payload %h, want %h", got.payload, want.payload));
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import cef_pkg::*;
	import cef_tb_pkg::*;

	localparam int ITEM_TARGET = 1050;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	int   idle_pct = 35;
	int   n_sent = 0;

	event_fifo_checker fifo_check = new();

	cef_req_if req();
	cef_rsp_if rsp();

	coalescing_event_fifo_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_t push_item(logic [5:0] k, logic [15:0] x, logic [15:0] y,
		logic [63:0] pl);
		req_t r;
		r.func = FUNC_PUSH;
		r.kind = k;
		r.pos_x = x;
		r.pos_y = y;
		r.payload = pl;
		return r;
	endfunction

	function automatic req_t rand_push();
		logic [5:0] k;
		// lean toward the special kinds so merges are common
		k = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 6)) : 6'($urandom_range(0, 63));
		return push_item(k, 16'($urandom), 16'($urandom), {$urandom, $urandom});
	endfunction

	function automatic req_t pop_item();
		req_t r;
		r = rand_push();
		r.func = FUNC_POP;
		return r;
	endfunction

	function automatic req_t mixed_item(int pop_pct);
		return ($urandom_range(0, 99) < pop_pct) ? pop_item() : rand_push();
	endfunction

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(req_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid   <= 1'b1;
		req.func    <= it.func;
		req.kind    <= it.kind;
		req.pos_x   <= it.pos_x;
		req.pos_y   <= it.pos_y;
		req.payload <= it.payload;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);
		fifo_check.take_request(it);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready)
			fifo_check.check_response('{rsp.status, rsp.out_kind, rsp.out_x, rsp.out_y,
				rsp.out_payload});
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		req_t it;
		int newest;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FUNC_PUSH;
		req.kind = EV_FRAME;
		req.pos_x = '0;
		req.pos_y = '0;
		req.payload = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, every kind, merges, extremes
		send_item(pop_item());
		send_item(push_item(EV_FRAME, 16'h0, 16'h0, 64'h0));
		send_item(push_item(EV_FRAME, 16'hffff, 16'hffff, 64'h1));
		send_item(push_item(EV_RESIZE, 16'h8000, 16'h7fff, 64'h0));
		send_item(push_item(EV_RESIZE, 16'h7fff, 16'h8000, 64'h0));
		send_item(push_item(EV_DRAG, 16'h0000, 16'hffff, 64'h0));
		send_item(push_item(EV_SCROLL, 16'h7fff, 16'h7fff, 64'h0));
		send_item(push_item(EV_SCROLL, 16'h0001, 16'h0001, 64'h0));
		send_item(push_item(EV_CLICK, 16'hffff, 16'h0000, 64'h0));
		send_item(push_item(EV_CLICK, 16'h1234, 16'habcd, 64'h0));
		send_item(push_item(EV_TEXT, 16'h5555, 16'haaaa, 64'hffff_ffff_ffff_ffff));
		send_item(push_item(EV_PASTE, 16'h0, 16'h0, 64'h8000_0000_0000_0001));
		send_item(push_item(6'd63, 16'hffff, 16'hffff, 64'hdead_beef_0123_4567));
		send_item(push_item(6'd63, 16'h0, 16'h0, 64'h0));
		repeat (11) send_item(pop_item());

		// fill to full, back to back for the first half
		idle_pct = 0;
		while (fifo_check.occupancy() < DEPTH - 1) begin
			if (fifo_check.occupancy() >= DEPTH / 2)
				idle_pct = 35;
			send_item(mixed_item(3));
		end

		// sit at full: refused pushes, merges into the newest entry, single pops
		repeat (30) begin
			it = mixed_item(20);
			newest = (fifo_check.wr + DEPTH - 1) % DEPTH;
			if ($urandom_range(0, 1) == 0)
				it.kind = fifo_check.kind_mem[newest];
			send_item(it);
		end

		while (fifo_check.occupancy() > 0)
			send_item(mixed_item(95));
		repeat (15) send_item(mixed_item(70));

		while (n_sent < ITEM_TARGET)
			send_item(mixed_item(50));

		req.valid <= 1'b0;
		while (fifo_check.awaited.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fifo_check.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
